@@ rtl/cwhs_pkg.sv @@
// shared types, constants and the arctangent table of the colour wheel mapper
`timescale 1ns / 1ps
package cwhs_pkg;

  localparam int COORD_BITS_DEF    = 10;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int PIXEL_W    = 10;
  localparam int WIDTH_W    = 11;
  localparam int LEVEL_W    = 17;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int HUE_W      = 16;
  localparam int SAT_W      = 17;
  localparam int DIV_W      = 12;
  localparam int ANGLE_W    = 32;
  localparam int ATAN_N     = 24;
  localparam int SQ_IN_W    = 34;
  localparam int ROOT_W     = 17;
  localparam int SQ_REM_W   = 21;
  localparam int SQ_CELLS   = SQ_IN_W / 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  localparam logic [WIDTH_W-1:0] SIZE_RESET  = 11'd256;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 17'd65536;
  localparam logic [LEVEL_W-1:0] LEVEL_UNIT  = 17'd65536;
  localparam logic [ANGLE_W-1:0] HALF_TURN   = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] HUE_ROUND   = 32'h0000_8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEEL_WIDTH  = 2'd0,
    REG_WHEEL_HEIGHT = 2'd1,
    REG_VALUE_LEVEL  = 2'd2
  } reg_index_t;

  // travels alongside the payload through every cell
  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic over;
    logic center;
  } ctl_t;

  // atan(2^-i) as a turn fraction, 2^32 is one turn
  function automatic logic [ANGLE_W-1:0] atan_turn(input int unsigned idx);
    logic [ANGLE_W-1:0] r;
    case (idx)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051D;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2E;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517C;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A2F;
      19: r = 32'h00000517;
      20: r = 32'h0000028B;
      21: r = 32'h00000145;
      22: r = 32'h000000A2;
      23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/cwhs_div_cell.sv @@
// one restoring division step for both axes, one quotient bit per cell
`timescale 1ns / 1ps
module cwhs_div_cell #(
  parameter int LOW_W = 18
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic [1:0][cwhs_pkg::DIV_W-1:0]    divisor,
  input  cwhs_pkg::ctl_t                     ctl_in,
  input  logic [1:0][cwhs_pkg::DIV_W-1:0]    rem_in,
  input  logic [1:0][LOW_W-1:0]              low_in,
  input  logic [1:0][LOW_W-1:0]              q_in,
  output cwhs_pkg::ctl_t                     ctl_out,
  output logic [1:0][cwhs_pkg::DIV_W-1:0]    rem_out,
  output logic [1:0][LOW_W-1:0]              low_out,
  output logic [1:0][LOW_W-1:0]              q_out
);
  import cwhs_pkg::*;

  logic [1:0][DIV_W:0]   trial;
  logic [1:0]            fits;
  logic [1:0][DIV_W-1:0] rem_next;
  logic [1:0][LOW_W-1:0] low_next;
  logic [1:0][LOW_W-1:0] q_next;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l]    = {rem_in[l], low_in[l][LOW_W-1]};
      fits[l]     = trial[l] >= {1'b0, divisor[l]};
      rem_next[l] = fits[l] ? DIV_W'(trial[l] - {1'b0, divisor[l]}) : trial[l][DIV_W-1:0];
      low_next[l] = {low_in[l][LOW_W-2:0], 1'b0};
      q_next[l]   = {q_in[l][LOW_W-2:0], fits[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      low_out <= low_next;
      q_out   <= q_next;
    end
  end

endmodule

@@ rtl/cwhs_cordic_cell.sv @@
// one vectoring rotation of the angle search
`timescale 1ns / 1ps
module cwhs_cordic_cell #(
  parameter int AW     = 20,
  parameter int IDX    = 0,
  parameter int SIDE_W = 34
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  cwhs_pkg::ctl_t                    ctl_in,
  input  logic signed [AW-1:0]              a_in,
  input  logic signed [AW-1:0]              b_in,
  input  logic [cwhs_pkg::ANGLE_W-1:0]      z_in,
  input  logic [SIDE_W-1:0]                 side_in,
  output cwhs_pkg::ctl_t                    ctl_out,
  output logic signed [AW-1:0]              a_out,
  output logic signed [AW-1:0]              b_out,
  output logic [cwhs_pkg::ANGLE_W-1:0]      z_out,
  output logic [SIDE_W-1:0]                 side_out
);
  import cwhs_pkg::*;

  localparam logic [ANGLE_W-1:0] STEP_ANGLE = atan_turn(IDX);

  logic signed [AW-1:0] a_sh;
  logic signed [AW-1:0] b_sh;
  logic signed [AW-1:0] a_next;
  logic signed [AW-1:0] b_next;
  logic [ANGLE_W-1:0]   z_next;

  always_comb begin
    a_sh = a_in >>> IDX;
    b_sh = b_in >>> IDX;
    // rotate towards the positive a axis
    if (!b_in[AW-1]) begin
      a_next = a_in + b_sh;
      b_next = b_in - a_sh;
      z_next = z_in + STEP_ANGLE;
    end else begin
      a_next = a_in - b_sh;
      b_next = b_in + a_sh;
      z_next = z_in - STEP_ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_out    <= a_next;
      b_out    <= b_next;
      z_out    <= z_next;
      side_out <= side_in;
    end
  end

endmodule

@@ rtl/cwhs_sqrt_cell.sv @@
// one digit of the bitwise square root, two radicand bits per cell
`timescale 1ns / 1ps
module cwhs_sqrt_cell #(
  parameter int SIDE_W = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  cwhs_pkg::ctl_t                    ctl_in,
  input  logic [cwhs_pkg::SQ_REM_W-1:0]     rem_in,
  input  logic [cwhs_pkg::ROOT_W-1:0]       root_in,
  input  logic [cwhs_pkg::SQ_IN_W-1:0]      bits_in,
  input  logic [SIDE_W-1:0]                 side_in,
  output cwhs_pkg::ctl_t                    ctl_out,
  output logic [cwhs_pkg::SQ_REM_W-1:0]     rem_out,
  output logic [cwhs_pkg::ROOT_W-1:0]       root_out,
  output logic [cwhs_pkg::SQ_IN_W-1:0]      bits_out,
  output logic [SIDE_W-1:0]                 side_out
);
  import cwhs_pkg::*;

  logic [SQ_REM_W-1:0] partial;
  logic [SQ_REM_W-1:0] trial;
  logic                fits;
  logic [SQ_REM_W-1:0] rem_next;
  logic [ROOT_W-1:0]   root_next;

  always_comb begin
    partial   = {rem_in[SQ_REM_W-3:0], bits_in[SQ_IN_W-1 -: 2]};
    trial     = SQ_REM_W'({root_in, 2'b01});
    fits      = partial >= trial;
    rem_next  = fits ? partial - trial : partial;
    root_next = {root_in[ROOT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      root_out <= root_next;
      bits_out <= {bits_in[SQ_IN_W-3:0], 2'b00};
      side_out <= side_in;
    end
  end

endmodule

@@ rtl/color_wheel_pixel_to_hue_sat.sv @@
// colour wheel mapper: pixel position to in-bounds flag, hue, saturation and value
//
//   channel  | direction | fields (lowest bit first)
//   ---------+-----------+-------------------------------------------------------
//   s_*      | in        | pixel_x[9:0], pixel_y[19:10]
//   m_*      | out       | in_bounds[0], hue[16:1], saturation[33:17], value_out[50:34]
//   cfg_*    | in        | 0 wheel_width, 1 wheel_height, 2 value_level
//
// one transaction per clock in and out while the output is not stalled. the pipeline
// is FRAC_BITS + 2 division cells, the rotation cells, 17 root cells and five single
// registers. the whole chain moves on one enable, which drops only
// while the output register holds a result that is not being taken.
// rst is synchronous and clears the valid bits and the configuration registers to their reset values.
`timescale 1ns / 1ps
module color_wheel_pixel_to_hue_sat #(
  parameter int COORD_BITS    = cwhs_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS     = cwhs_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = cwhs_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [cwhs_pkg::IN_DATA_W-1:0]     s_tdata,   // pixel_x, pixel_y
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [cwhs_pkg::OUT_DATA_W-1:0]    m_tdata,   // in_bounds, hue, saturation, value_out
  input  logic                               cfg_we,
  input  logic [cwhs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cwhs_pkg::CFG_W-1:0]         cfg_data
);
  import cwhs_pkg::*;

  localparam int PW      = (COORD_BITS < PIXEL_W) ? COORD_BITS : PIXEL_W;
  localparam int LOW_W   = FRAC_BITS + 2;
  localparam int NW      = WIDTH_W + LOW_W;
  localparam int NDIV    = LOW_W;
  localparam int AW      = FRAC_BITS + 4;
  localparam int SUM_W   = 2 * LOW_W + 1;
  localparam int NCS     = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
  localparam logic [LOW_W-1:0] Q_ONE   = LOW_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0] SUM_ONE = SUM_W'(1) << (2 * FRAC_BITS);

  logic en;

  // configuration
  logic [WIDTH_W-1:0] wheel_width;
  logic [WIDTH_W-1:0] wheel_height;
  logic [LEVEL_W-1:0] value_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_width  <= SIZE_RESET;
      wheel_height <= SIZE_RESET;
      value_level  <= LEVEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WHEEL_WIDTH:  wheel_width  <= cfg_data[WIDTH_W-1:0];
        REG_WHEEL_HEIGHT: wheel_height <= cfg_data[WIDTH_W-1:0];
        REG_VALUE_LEVEL:  value_level  <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [1:0][WIDTH_W-1:0] size_eff;
  logic [1:0][DIV_W-1:0]   divisor;
  logic [LEVEL_W-1:0]      level_sat;

  always_comb begin
    // a size of zero counts as one
    size_eff[0] = (wheel_width  == '0) ? WIDTH_W'(1) : wheel_width;
    size_eff[1] = (wheel_height == '0) ? WIDTH_W'(1) : wheel_height;
    divisor[0]  = {size_eff[0], 1'b0};
    divisor[1]  = {size_eff[1], 1'b0};
    level_sat   = (value_level > LEVEL_UNIT) ? LEVEL_UNIT : value_level;
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input stage: |2p - d| scaled up with the rounding term, ready for division
  logic [1:0][PW-1:0]      pix;
  logic [1:0][WIDTH_W-1:0] twice;
  logic [1:0][WIDTH_W-1:0] mag;
  logic [1:0]              pos;
  logic [1:0]              big;
  logic [1:0][NW-1:0]      num;
  ctl_t                    a_ctl_next;
  ctl_t                    a_ctl;
  logic [1:0][DIV_W-1:0]   a_rem;
  logic [1:0][LOW_W-1:0]   a_low;

  always_comb begin
    pix[0] = s_tdata[PW-1:0];
    pix[1] = s_tdata[PIXEL_W +: PW];
    for (int l = 0; l < 2; l++) begin
      twice[l] = WIDTH_W'({pix[l], 1'b0});
      pos[l]   = twice[l] >= size_eff[l];
      mag[l]   = pos[l] ? twice[l] - size_eff[l] : size_eff[l] - twice[l];
      // quotient would not fit the divider: surely beyond one
      big[l]   = {2'b00, mag[l]} >= {size_eff[l], 2'b00};
      num[l]   = (NW'(mag[l]) << (FRAC_BITS + 1)) + NW'(size_eff[l]);
    end
    a_ctl_next.valid  = s_tvalid;
    a_ctl_next.neg_x  = !pos[0];
    a_ctl_next.neg_y  = !pos[1];
    a_ctl_next.over   = big[0] || big[1];
    a_ctl_next.center = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else if (en) begin
      a_ctl <= a_ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        a_rem[l] <= DIV_W'(num[l][NW-1:LOW_W]);
        a_low[l] <= num[l][LOW_W-1:0];
      end
    end
  end

  // division chain
  ctl_t                  div_ctl [0:NDIV];
  logic [1:0][DIV_W-1:0] div_rem [0:NDIV];
  logic [1:0][LOW_W-1:0] div_low [0:NDIV];
  logic [1:0][LOW_W-1:0] div_q   [0:NDIV];

  assign div_ctl[0] = a_ctl;
  assign div_rem[0] = a_rem;
  assign div_low[0] = a_low;
  assign div_q[0]   = '0;

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    cwhs_div_cell #(
      .LOW_W (LOW_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .divisor (divisor),
      .ctl_in  (div_ctl[g]),
      .rem_in  (div_rem[g]),
      .low_in  (div_low[g]),
      .q_in    (div_q[g]),
      .ctl_out (div_ctl[g+1]),
      .rem_out (div_rem[g+1]),
      .low_out (div_low[g+1]),
      .q_out   (div_q[g+1])
    );
  end

  // squares and signed axes
  ctl_t                     b_ctl_next;
  ctl_t                     b_ctl;
  logic [1:0][2*LOW_W-1:0]  b_sq;
  logic signed [LOW_W:0]    b_dx;
  logic signed [LOW_W:0]    b_dy;
  logic [1:0][LOW_W-1:0]    q_fin;

  always_comb begin
    q_fin           = div_q[NDIV];
    b_ctl_next      = div_ctl[NDIV];
    b_ctl_next.over = div_ctl[NDIV].over || (q_fin[0] > Q_ONE) || (q_fin[1] > Q_ONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl <= '0;
    end else if (en) begin
      b_ctl <= b_ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        b_sq[l] <= {{LOW_W{1'b0}}, q_fin[l]} * {{LOW_W{1'b0}}, q_fin[l]};
      end
      b_dx <= div_ctl[NDIV].neg_x ? -$signed({1'b0, q_fin[0]}) : $signed({1'b0, q_fin[0]});
      b_dy <= div_ctl[NDIV].neg_y ? -$signed({1'b0, q_fin[1]}) : $signed({1'b0, q_fin[1]});
    end
  end

  // radius check, root scaling and half-plane fold for the rotations
  logic [SUM_W-1:0]     sum_c;
  logic [SQ_IN_W-1:0]   scaled_c;
  logic signed [AW-1:0] dx_e;
  logic signed [AW-1:0] dy_e;
  logic signed [AW-1:0] up_c;
  logic signed [AW-1:0] a_c;
  logic signed [AW-1:0] b_c;
  logic [ANGLE_W-1:0]   z_c;
  ctl_t                 c_ctl_next;
  ctl_t                 c_ctl;
  logic signed [AW-1:0] c_a;
  logic signed [AW-1:0] c_b;
  logic [ANGLE_W-1:0]   c_z;
  logic [SQ_IN_W-1:0]   c_scaled;

  if (FRAC_BITS >= 16) begin : g_down
    assign scaled_c = SQ_IN_W'(sum_c >> (2 * (FRAC_BITS - 16)));
  end else begin : g_up
    assign scaled_c = SQ_IN_W'({sum_c, {(2 * (16 - FRAC_BITS)){1'b0}}});
  end

  always_comb begin
    sum_c = SUM_W'(b_sq[0]) + SUM_W'(b_sq[1]);
    dx_e  = AW'(b_dx);
    dy_e  = AW'(b_dy);
    up_c  = -dy_e;
    // lower half: turn half way round first
    if (up_c[AW-1]) begin
      a_c = dy_e;
      b_c = -dx_e;
      z_c = HALF_TURN;
    end else begin
      a_c = up_c;
      b_c = dx_e;
      z_c = '0;
    end
    c_ctl_next        = b_ctl;
    c_ctl_next.over   = b_ctl.over || (sum_c > SUM_ONE);
    c_ctl_next.center = (b_dx == '0) && (b_dy == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl <= '0;
    end else if (en) begin
      c_ctl <= c_ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_a      <= a_c;
      c_b      <= b_c;
      c_z      <= z_c;
      c_scaled <= scaled_c;
    end
  end

  // rotation chain
  ctl_t                 cor_ctl  [0:NCS];
  logic signed [AW-1:0] cor_a    [0:NCS];
  logic signed [AW-1:0] cor_b    [0:NCS];
  logic [ANGLE_W-1:0]   cor_z    [0:NCS];
  logic [SQ_IN_W-1:0]   cor_side [0:NCS];

  assign cor_ctl[0]  = c_ctl;
  assign cor_a[0]    = c_a;
  assign cor_b[0]    = c_b;
  assign cor_z[0]    = c_z;
  assign cor_side[0] = c_scaled;

  for (genvar g = 0; g < NCS; g++) begin : g_cordic
    cwhs_cordic_cell #(
      .AW     (AW),
      .IDX    (g),
      .SIDE_W (SQ_IN_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (cor_ctl[g]),
      .a_in     (cor_a[g]),
      .b_in     (cor_b[g]),
      .z_in     (cor_z[g]),
      .side_in  (cor_side[g]),
      .ctl_out  (cor_ctl[g+1]),
      .a_out    (cor_a[g+1]),
      .b_out    (cor_b[g+1]),
      .z_out    (cor_z[g+1]),
      .side_out (cor_side[g+1])
    );
  end

  // hue rounding
  logic [ANGLE_W-1:0] z_round;
  ctl_t               d_ctl;
  logic [HUE_W-1:0]   d_hue;
  logic [SQ_IN_W-1:0] d_scaled;

  assign z_round = cor_z[NCS] + HUE_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl <= '0;
    end else if (en) begin
      d_ctl <= cor_ctl[NCS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_hue    <= cor_ctl[NCS].center ? '0 : z_round[ANGLE_W-1 -: HUE_W];
      d_scaled <= cor_side[NCS];
    end
  end

  // root chain
  ctl_t                sq_ctl  [0:SQ_CELLS];
  logic [SQ_REM_W-1:0] sq_rem  [0:SQ_CELLS];
  logic [ROOT_W-1:0]   sq_root [0:SQ_CELLS];
  logic [SQ_IN_W-1:0]  sq_bits [0:SQ_CELLS];
  logic [HUE_W-1:0]    sq_side [0:SQ_CELLS];

  assign sq_ctl[0]  = d_ctl;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_bits[0] = d_scaled;
  assign sq_side[0] = d_hue;

  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sqrt
    cwhs_sqrt_cell #(
      .SIDE_W (HUE_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (sq_ctl[g]),
      .rem_in   (sq_rem[g]),
      .root_in  (sq_root[g]),
      .bits_in  (sq_bits[g]),
      .side_in  (sq_side[g]),
      .ctl_out  (sq_ctl[g+1]),
      .rem_out  (sq_rem[g+1]),
      .root_out (sq_root[g+1]),
      .bits_out (sq_bits[g+1]),
      .side_out (sq_side[g+1])
    );
  end

  // output register, root rounded half up
  logic             round_up;
  logic [SAT_W-1:0] sat_next;
  logic             o_in_bounds;
  logic [HUE_W-1:0] o_hue;
  logic [SAT_W-1:0] o_sat;
  logic [LEVEL_W-1:0] o_value;

  assign round_up = sq_rem[SQ_CELLS] > SQ_REM_W'(sq_root[SQ_CELLS]);
  assign sat_next = SAT_W'(sq_root[SQ_CELLS] + ROOT_W'(round_up));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= sq_ctl[SQ_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_in_bounds <= !sq_ctl[SQ_CELLS].over;
      o_hue       <= sq_ctl[SQ_CELLS].over ? '0 : sq_side[SQ_CELLS];
      o_sat       <= sq_ctl[SQ_CELLS].over ? '0 : sat_next;
      o_value     <= sq_ctl[SQ_CELLS].over ? '0 : level_sat;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - 1 - HUE_W - SAT_W - LEVEL_W){1'b0}},
                    o_value, o_sat, o_hue, o_in_bounds};

endmodule

@@ rtl/cwhs_checker.sv @@
// port checks of the colour wheel mapper and their binding
`timescale 1ns / 1ps
module cwhs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cwhs_pkg::OUT_DATA_W-1:0] m_tdata
);
  import cwhs_pkg::*;

  // a waiting result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  // a blocked output stops the input side as well
  a_back_pressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  // outside the wheel every field is zero
  a_out_of_wheel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[OUT_DATA_W-1:1] == '0)
    else $error("out of bounds result not cleared");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:17] <= 17'd65536) && (m_tdata[50:34] <= 17'd65536))
    else $error("saturation or value beyond one");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown straight after reset");

endmodule

bind color_wheel_pixel_to_hue_sat cwhs_checker u_cwhs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ test/tb.sv @@
// self-checking testbench for the colour wheel pixel to hue and saturation mapper
`timescale 1ns / 1ps
module tb;
  import cwhs_pkg::*;

  localparam int PIPE_LATENCY = 56;
  localparam int STALL_LIMIT  = 4000;
  localparam int FRAC         = 16;
  localparam int ROT_STAGES   = 16;
  localparam int RANDOM_PER_SETTING = 225;

  localparam logic [ANGLE_W-1:0] ROT_STEP [ROT_STAGES] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
  };

  typedef struct packed {
    logic [PIXEL_W-1:0] y;
    logic [PIXEL_W-1:0] x;
  } pixel_t;

  typedef struct {
    logic             in_bounds;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [LEVEL_W-1:0] value_out;
  } shade_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;   // pixel_x, pixel_y
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;       // in_bounds, hue, saturation, value_out
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic hold_steady = 1'b0;

  // register copies used for prediction
  logic [WIDTH_W-1:0] wheel_w_copy = SIZE_RESET;
  logic [WIDTH_W-1:0] wheel_h_copy = SIZE_RESET;
  logic [LEVEL_W-1:0] level_copy   = LEVEL_RESET;

  pixel_t pixel_queue[$];
  shade_t expected_shades[$];

  int mismatch_count = 0;
  int pixels_sent    = 0;
  int shades_checked = 0;
  int inside_seen    = 0;
  int settings_used  = 0;
  int stall_cycles   = 0;

  color_wheel_pixel_to_hue_sat DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // 2p/d - 1 in Q.16, halves away from zero
  function automatic longint axis_offset(longint unsigned p, longint unsigned d);
    longint unsigned twice, mag, q;
    twice = p * 2;
    mag = (twice >= d) ? twice - d : d - twice;
    q = ((mag << FRAC) * 2 + d) / (2 * d);
    return (twice >= d) ? longint'(q) : -longint'(q);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned root, probe;
    root = 0;
    probe = 64'h1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // vectoring rotation: clockwise turn fraction of (up, right)
  function automatic logic [ANGLE_W-1:0] clockwise_turn(longint up, longint right);
    logic [ANGLE_W-1:0] z;
    longint nu, nr;
    z = '0;
    if (up < 0) begin
      up = -up;
      right = -right;
      z = HALF_TURN;
    end
    for (int i = 0; i < ROT_STAGES; i++) begin
      if (right >= 0) begin
        nu = up + (right >>> i);
        nr = right - (up >>> i);
        z = z + ROT_STEP[i];
      end else begin
        nu = up - (right >>> i);
        nr = right + (up >>> i);
        z = z - ROT_STEP[i];
      end
      up = nu;
      right = nr;
    end
    return z;
  endfunction

  function automatic shade_t predict_shade(pixel_t px);
    shade_t s;
    longint unsigned w, h, sum, root;
    longint dx, dy, unit;
    logic [ANGLE_W-1:0] rounded;
    s = '{1'b0, '0, '0, '0};
    w = (wheel_w_copy == 0) ? 1 : wheel_w_copy;
    h = (wheel_h_copy == 0) ? 1 : wheel_h_copy;
    unit = longint'(1) << FRAC;
    dx = axis_offset(px.x, w);
    dy = axis_offset(px.y, h);
    if (dx > unit || dx < -unit || dy > unit || dy < -unit) return s;
    sum = dx * dx + dy * dy;
    if (sum > (64'h1 << (2 * FRAC))) return s;
    root = root_floor(sum);
    if (sum - root * root > root) root = root + 1;
    s.in_bounds = 1'b1;
    if (dx != 0 || dy != 0) begin
      rounded = clockwise_turn(-dy, dx) + HUE_ROUND;
      s.hue = rounded[ANGLE_W-1:ANGLE_W-HUE_W];
    end
    s.saturation = root[SAT_W-1:0];
    s.value_out = (level_copy > LEVEL_UNIT) ? LEVEL_UNIT : level_copy;
    return s;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_shades.push_back(predict_shade(pixel_t'(s_tdata[2*PIXEL_W-1:0])));
        pixels_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_queue.size() != 0 && (hold_steady || $urandom_range(99) >= 18)) begin
          s_tvalid <= 1'b1;
          s_tdata <= {{(IN_DATA_W - 2*PIXEL_W){1'b0}}, pixel_queue.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("tb: %s expected %0d got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    shade_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= hold_steady || ($urandom_range(99) >= 18);
      if (m_tvalid && m_tready) begin
        if (expected_shades.size() == 0) begin
          $error("tb: result transaction with nothing expected");
          mismatch_count++;
        end else begin
          want = expected_shades.pop_front();
          check_field("in_bounds", want.in_bounds, m_tdata[0]);
          check_field("hue", want.hue, m_tdata[16:1]);
          check_field("saturation", want.saturation, m_tdata[33:17]);
          check_field("value_out", want.value_out, m_tdata[50:34]);
          if (want.in_bounds) inside_seen++;
          shades_checked++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pixel_queue.size() != 0 || s_tvalid || expected_shades.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_WHEEL_WIDTH:  wheel_w_copy = val[WIDTH_W-1:0];
      REG_WHEEL_HEIGHT: wheel_h_copy = val[WIDTH_W-1:0];
      REG_VALUE_LEVEL:  level_copy = val;
      default: ;
    endcase
  endtask

  // drain, let the pipeline empty, then load a new wheel setting
  task automatic set_wheel(int w, int h, int lvl, logic steady);
    wait_drained();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    hold_steady <= steady;
    write_reg(REG_WHEEL_WIDTH, CFG_W'(w));
    write_reg(REG_WHEEL_HEIGHT, CFG_W'(h));
    write_reg(REG_VALUE_LEVEL, CFG_W'(lvl));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic push_pixel(int x, int y);
    pixel_t px;
    px.x = PIXEL_W'(x);
    px.y = PIXEL_W'(y);
    pixel_queue.push_back(px);
  endtask

  // mostly inside the wheel box, with centre, axis and rim hits and full-range noise
  task automatic queue_random(int count);
    int span_x, span_y, pick, x, y;
    span_x = (wheel_w_copy == 0) ? 1 : ((wheel_w_copy > 1023) ? 1023 : wheel_w_copy);
    span_y = (wheel_h_copy == 0) ? 1 : ((wheel_h_copy > 1023) ? 1023 : wheel_h_copy);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      x = $urandom_range(span_x);
      y = $urandom_range(span_y);
      if (pick < 5) begin
        x = span_x / 2;
        y = span_y / 2;
      end else if (pick < 10) begin
        x = (pick[0]) ? 0 : span_x;
      end else if (pick < 15) begin
        y = (pick[0]) ? 0 : span_y;
      end else if (pick < 20) begin
        x = span_x / 2;
      end else if (pick >= 82) begin
        x = $urandom_range(1023);
        y = $urandom_range(1023);
      end
      push_pixel(x, y);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_wheel(256, 256, 65536, 1'b0);
    // compass points, centre, corners and rim
    push_pixel(128, 128);
    push_pixel(128, 0);
    push_pixel(256, 128);
    push_pixel(128, 256);
    push_pixel(0, 128);
    push_pixel(192, 64);
    push_pixel(64, 192);
    push_pixel(40, 40);
    push_pixel(216, 216);
    push_pixel(37, 37);
    push_pixel(127, 128);
    push_pixel(129, 128);
    push_pixel(128, 127);
    push_pixel(1, 128);
    push_pixel(128, 1);
    push_pixel(255, 255);
    push_pixel(85, 170);
    push_pixel(0, 0);
    push_pixel(1023, 1023);
    push_pixel(1023, 0);
    push_pixel(0, 1023);
    push_pixel(341, 682);
    push_pixel(682, 341);

    set_wheel(1, 1, 0, 1'b0);
    queue_random(RANDOM_PER_SETTING);
    set_wheel(1024, 1024, 65536, 1'b0);
    queue_random(RANDOM_PER_SETTING);
    // zero size acts as one, value above one clips
    set_wheel(0, 0, 131071, 1'b0);
    queue_random(RANDOM_PER_SETTING);
    set_wheel(2047, 2047, 65535, 1'b0);
    queue_random(RANDOM_PER_SETTING);
    set_wheel(640, 480, 40000, 1'b0);
    queue_random(RANDOM_PER_SETTING);
    set_wheel(3, 1000, $urandom_range(65536), 1'b1);
    queue_random(RANDOM_PER_SETTING);
    set_wheel(256, 256, 32768, 1'b0);
    queue_random(RANDOM_PER_SETTING);

    wait_drained();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    $display("tb: %0d pixels over %0d wheel settings, %0d results checked (%0d inside)",
             pixels_sent, settings_used, shades_checked, inside_seen);
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cwhs_pkg.sv
rtl/cwhs_div_cell.sv
rtl/cwhs_cordic_cell.sv
rtl/cwhs_sqrt_cell.sv
rtl/color_wheel_pixel_to_hue_sat.sv
rtl/cwhs_checker.sv
test/tb.sv
